@@ src/dwt4_pkg.sv @@
// Shared types, constants and filter coefficients of the D4 wavelet block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package dwt4_pkg;

   // Sizing of the datapath and the block.
   localparam int MAX_HALF       = 512;
   localparam int VALUE_WIDTH    = 20;
   localparam int COEF_FRAC_BITS = 16;
   localparam int HALF_W         = 10;
   localparam int INDEX_W        = 9;
   localparam int COUNT_W        = 9;

   // Configuration port.
   localparam int CFG_INDEX_W = 2;
   localparam int CFG_DATA_W  = 10;
   localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION   = CFG_INDEX_W'(0);
   localparam logic [CFG_INDEX_W-1:0] CFG_HALF_LENGTH = CFG_INDEX_W'(1);
   localparam logic [HALF_W-1:0]      HALF_RESET      = HALF_W'(512);

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = ((2 * VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 2 * VALUE_WIDTH + INDEX_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Arithmetic widths: coefficients stay below 2 in magnitude.
   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam int PROD_W = VALUE_WIDTH + COEF_W;
   localparam int SUM_W  = PROD_W + 2;

   // Job queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // Round a Q24 magnitude half up to the working number of fraction bits.
   function automatic int coef_of(input int mag_q24);
      int shift;
      shift = 24 - COEF_FRAC_BITS;
      if (shift <= 0) begin
         return mag_q24;
      end
      return (mag_q24 + (1 << (shift - 1))) >>> shift;
   endfunction

   localparam logic signed [COEF_W-1:0] H0     = COEF_W'(coef_of(8102773));
   localparam logic signed [COEF_W-1:0] H1     = COEF_W'(coef_of(14034415));
   localparam logic signed [COEF_W-1:0] H2     = COEF_W'(coef_of(3760510));
   localparam logic signed [COEF_W-1:0] H3     = COEF_W'(-coef_of(2171132));
   localparam logic signed [COEF_W-1:0] NEG_H0 = COEF_W'(-coef_of(8102773));
   localparam logic signed [COEF_W-1:0] NEG_H2 = COEF_W'(-coef_of(3760510));

   // One result to compute: the earlier pair p, the later pair c and tags.
   typedef struct packed {
      logic                          inverse;
      logic signed [VALUE_WIDTH-1:0] p0;
      logic signed [VALUE_WIDTH-1:0] p1;
      logic signed [VALUE_WIDTH-1:0] c0;
      logic signed [VALUE_WIDTH-1:0] c1;
      logic [INDEX_W-1:0]            index;
      logic                          last;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } slot_type;

endpackage

@@ src/daubechies4_wavelet_transform.sv @@
// One level of the periodic Daubechies D4 wavelet transform.
//
// Input stream (req_): one pair per item, even/odd samples in forward mode,
// low/high coefficients in inverse mode. Output stream (rsp_): one result
// pair per item after the first of a block, plus the wrap-around pair after
// the block's last item, flagged with rsp_tlast and carrying its pair index.
// Configuration (csr_): register 0 selects the direction, register 1 sets
// the number of pairs per block; a write to either register restarts the block position.
// Write only while no results are outstanding.
//
// Throughput is one item per cycle while the queue is not full; a block of N
// pairs yields N results. A neighbor result passes through the queue write,
// the product stage, the sum stage and the rounding/output stage; the wrap
// pair first waits in the front end until the queue takes it.
// When rsp_tready is low the back end holds; the four-entry job queue keeps
// taking items until it fills, and then req_tready drops.
// Reset (synchronous) empties the queue and pipeline, selects forward mode
// and a block of 512 pairs.
module daubechies4_wavelet_transform (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dwt4_pkg::CFG_INDEX_W-1:0]    csr_index,
   input  logic [dwt4_pkg::CFG_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: first_value, second_value.
   input  logic [dwt4_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: low_or_even, high_or_odd, pair_index, zero padding.
   output logic [dwt4_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import dwt4_pkg::*;

   slot_type                      push, head;
   logic                          queue_full, pop;
   logic signed [VALUE_WIDTH-1:0] first_value, second_value;
   logic signed [VALUE_WIDTH-1:0] low_or_even, high_or_odd;
   logic [INDEX_W-1:0]            pair_index;

   // Unpack the input payload.
   assign first_value  = req_tdata[VALUE_WIDTH-1:0];
   assign second_value = req_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];

   dwt4_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .first_value  (first_value),
      .second_value (second_value),
      .queue_full   (queue_full),
      .push         (push)
   );

   dwt4_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   dwt4_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .low_or_even (low_or_even),
      .high_or_odd (high_or_odd),
      .pair_index  (pair_index),
      .block_end   (rsp_tlast)
   );

   // Pack the result payload.
   assign rsp_tdata = RSP_DATA_W'({pair_index, high_or_odd, low_or_even});

endmodule

@@ src/dwt4_front.sv @@
// Front end of the D4 wavelet block: configuration registers, block position
// tracking and generation of result jobs. Depends on dwt4_pkg.
module dwt4_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dwt4_pkg::CFG_INDEX_W-1:0]     csr_index,
   input  logic [dwt4_pkg::CFG_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic signed [dwt4_pkg::VALUE_WIDTH-1:0] first_value,
   input  logic signed [dwt4_pkg::VALUE_WIDTH-1:0] second_value,
   input  logic                                 queue_full,
   output dwt4_pkg::slot_type                   push
);
   import dwt4_pkg::*;

   logic                          inverse_ff, inverse_in;
   logic [HALF_W-1:0]             half_ff, half_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic signed [VALUE_WIDTH-1:0] first0_ff, first1_ff, prev0_ff, prev1_ff;
   logic                          wrap_pending_ff, wrap_pending_in;
   job_type                       wrap_job_ff, wrap_job_in;

   logic [HALF_W-1:0]  active_half, last_k;
   logic [COUNT_W-1:0] k;
   logic               accept, is_last, wrap_push, cfg_hit;

   // Clamp the programmed length into the supported range.
   always_comb begin
      if (half_ff < HALF_W'(2)) begin
         active_half = HALF_W'(2);
      end else if (half_ff > HALF_W'(MAX_HALF)) begin
         active_half = HALF_W'(MAX_HALF);
      end else begin
         active_half = half_ff;
      end
      last_k = active_half - HALF_W'(1);
   end

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign k          = ({1'b0, count_ff} >= active_half) ? '0 : count_ff;
   assign is_last    = ({1'b0, k} == last_k);
   assign wrap_push  = wrap_pending_ff && !queue_full;

   // Job generation: a pending wrap pair goes first; an item opening a
   // block never produces a job, so the two never collide.
   always_comb begin
      push = '0;
      if (wrap_push) begin
         push.valid = 1'b1;
         push.job   = wrap_job_ff;
      end else if (accept && (k != '0)) begin
         push.valid       = 1'b1;
         push.job.inverse = inverse_ff;
         push.job.p0      = prev0_ff;
         push.job.p1      = prev1_ff;
         push.job.c0      = first_value;
         push.job.c1      = second_value;
         push.job.index   = inverse_ff ? INDEX_W'(k) : INDEX_W'(k - COUNT_W'(1));
         push.job.last    = 1'b0;
      end
   end

   // Wrap pair of the block's last item, held until the queue takes it.
   always_comb begin
      wrap_job_in         = wrap_job_ff;
      wrap_job_in.inverse = inverse_ff;
      wrap_job_in.p0      = first_value;
      wrap_job_in.p1      = second_value;
      wrap_job_in.c0      = first0_ff;
      wrap_job_in.c1      = first1_ff;
      wrap_job_in.index   = inverse_ff ? '0 : INDEX_W'(last_k);
      wrap_job_in.last    = 1'b1;
      wrap_pending_in     = wrap_pending_ff;
      if (wrap_push) begin
         wrap_pending_in = 1'b0;
      end
      if (accept && is_last) begin
         wrap_pending_in = 1'b1;
      end
   end

   // Configuration writes and block position.
   always_comb begin
      inverse_in = inverse_ff;
      half_in    = half_ff;
      cfg_hit    = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CFG_DIRECTION: begin
               inverse_in = csr_wdata[0];
               cfg_hit    = 1'b1;
            end
            CFG_HALF_LENGTH: begin
               half_in = csr_wdata[HALF_W-1:0];
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      count_in = count_ff;
      if (accept) begin
         count_in = is_last ? '0 : k + COUNT_W'(1);
      end
      if (cfg_hit) begin
         count_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff      <= 1'b0;
         half_ff         <= HALF_RESET;
         count_ff        <= '0;
         wrap_pending_ff <= 1'b0;
      end else begin
         inverse_ff      <= inverse_in;
         half_ff         <= half_in;
         count_ff        <= count_in;
         wrap_pending_ff <= wrap_pending_in;
      end
   end

   // Stored pairs and the held wrap job.
   always_ff @(posedge clock) begin
      if (accept) begin
         prev0_ff <= first_value;
         prev1_ff <= second_value;
         if (k == '0) begin
            first0_ff <= first_value;
            first1_ff <= second_value;
         end
         if (is_last) begin
            wrap_job_ff <= wrap_job_in;
         end
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !queue_full)
      else $error("job pushed into a full queue");
   a_wrap_opens_block: assert property (@(posedge clock) disable iff (reset)
      wrap_pending_ff |-> (count_ff == '0))
      else $error("wrap pair pending while a block is in progress");
   a_last_sets_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && is_last && !cfg_hit) |=> wrap_pending_ff)
      else $error("last item of a block did not schedule its wrap pair");
`endif

endmodule

@@ src/dwt4_queue.sv @@
// Short job queue between the front and back ends of the D4 wavelet block.
// Depends on dwt4_pkg.
module dwt4_queue (
   input  logic               clock,
   input  logic               reset,
   input  dwt4_pkg::slot_type push,
   output logic               full,
   output dwt4_pkg::slot_type head,
   input  logic               pop
);
   import dwt4_pkg::*;

   job_type                slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic                   do_push, do_pop;

   assign full       = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = slots_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QUEUE_PTR_W + 1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QUEUE_PTR_W + 1)'(1);
         end
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

@@ src/dwt4_back.sv @@
// Back end of the D4 wavelet block: constant-coefficient products, sums,
// rounding and saturation in three stages ending in the output register.
// Depends on dwt4_pkg.
module dwt4_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dwt4_pkg::slot_type                   head,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [dwt4_pkg::VALUE_WIDTH-1:0] low_or_even,
   output logic signed [dwt4_pkg::VALUE_WIDTH-1:0] high_or_odd,
   output logic [dwt4_pkg::INDEX_W-1:0]         pair_index,
   output logic                                 block_end
);
   import dwt4_pkg::*;

   localparam logic signed [SUM_W:0] ROUND_HALF =
      (SUM_W + 1)'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [SUM_W:0] SAT_HI =
      (SUM_W + 1)'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_W:0] SAT_LO =
      (SUM_W + 1)'(-(64'sd1 <<< (VALUE_WIDTH - 1)));

   function automatic logic signed [PROD_W-1:0] mul(
      input logic signed [VALUE_WIDTH-1:0] v,
      input logic signed [COEF_W-1:0]      c
   );
      return PROD_W'(v) * PROD_W'(c);
   endfunction

   // Round to nearest with ties upward, then clamp to the value range.
   function automatic logic signed [VALUE_WIDTH-1:0] round_sat(
      input logic signed [SUM_W-1:0] s
   );
      logic signed [SUM_W:0] t;
      logic signed [SUM_W:0] q;
      t = (SUM_W + 1)'(s) + ROUND_HALF;
      q = t >>> COEF_FRAC_BITS;
      if (q > SAT_HI) begin
         q = SAT_HI;
      end else if (q < SAT_LO) begin
         q = SAT_LO;
      end
      return q[VALUE_WIDTH-1:0];
   endfunction

   logic                     enable;
   logic                     a_valid_ff, b_valid_ff;
   logic signed [PROD_W-1:0] e0_ff, e1_ff, e2_ff, e3_ff;
   logic signed [PROD_W-1:0] o0_ff, o1_ff, o2_ff, o3_ff;
   logic signed [SUM_W-1:0]  even_sum_ff, odd_sum_ff;
   logic [INDEX_W-1:0]       a_index_ff, b_index_ff;
   logic                     a_last_ff, b_last_ff;
   logic signed [COEF_W-1:0] k_p0, k_c0, k_p1n, k_c1n;

   // The whole pipeline moves whenever the output register can take data.
   assign enable = !rsp_tvalid || rsp_tready;
   assign pop    = enable && head.valid;

   // Coefficient choice for the two directions.
   assign k_p0  = head.job.inverse ? H2 : H0;
   assign k_c0  = head.job.inverse ? H0 : H2;
   assign k_p1n = head.job.inverse ? NEG_H0 : NEG_H2;
   assign k_c1n = head.job.inverse ? NEG_H2 : NEG_H0;

   // Valid flags of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= head.valid;
         b_valid_ff <= a_valid_ff;
         rsp_tvalid <= b_valid_ff;
      end
   end

   // Products, sums and the output register.
   always_ff @(posedge clock) begin
      if (enable) begin
         e0_ff      <= mul(head.job.p0, k_p0);
         e1_ff      <= mul(head.job.p1, H1);
         e2_ff      <= mul(head.job.c0, k_c0);
         e3_ff      <= mul(head.job.c1, H3);
         o0_ff      <= mul(head.job.p0, H3);
         o1_ff      <= mul(head.job.p1, k_p1n);
         o2_ff      <= mul(head.job.c0, H1);
         o3_ff      <= mul(head.job.c1, k_c1n);
         a_index_ff <= head.job.index;
         a_last_ff  <= head.job.last;

         even_sum_ff <= SUM_W'(e0_ff) + SUM_W'(e1_ff) + SUM_W'(e2_ff) + SUM_W'(e3_ff);
         odd_sum_ff  <= SUM_W'(o0_ff) + SUM_W'(o1_ff) + SUM_W'(o2_ff) + SUM_W'(o3_ff);
         b_index_ff  <= a_index_ff;
         b_last_ff   <= a_last_ff;

         low_or_even <= round_sat(even_sum_ff);
         high_or_odd <= round_sat(odd_sum_ff);
         pair_index  <= b_index_ff;
         block_end   <= b_last_ff;
      end
   end

endmodule
